>>> rtl/core/ustd_pkg.sv
// Shared types, constants and calendar helpers for the seconds-to-date converter.
package ustd_pkg;

    // Seconds count is divided by 128 first, then by 675 (86400 = 128 * 675)
    localparam int unsigned SEC_LO_BITS  = 7;
    localparam logic [9:0]  DAY_DIV_HI   = 10'd675;
    localparam logic [25:0] DAY_RECIP    = 26'd50903317;   // ceil(2^35 / 675)
    localparam int unsigned DAY_SHIFT    = 35;

    // Time of day
    localparam logic [15:0] HOUR_RECIP   = 16'd37283;      // ceil(2^27 / 3600)
    localparam int unsigned HOUR_SHIFT   = 27;
    localparam logic [11:0] SECS_PER_HR  = 12'd3600;
    localparam logic [11:0] MIN_RECIP    = 12'd2185;       // ceil(2^17 / 60)
    localparam int unsigned MIN_SHIFT    = 17;
    localparam logic [5:0]  SECS_PER_MN  = 6'd60;

    // Date: days counted from 1968-01-01, in four-year blocks
    localparam logic [15:0] EPOCH_OFFSET = 16'd731;        // 1968-01-01 .. 1970-01-01
    localparam logic [15:0] SKIP_2100    = 16'd47541;      // day number of 2100-03-01, counted from 1970-01-01
    localparam logic [15:0] QUAD_RECIP   = 16'd45934;      // ceil(2^26 / 1461)
    localparam int unsigned QUAD_SHIFT   = 26;
    localparam logic [10:0] DAYS_PER_QD  = 11'd1461;
    localparam logic [10:0] QD_YEAR1     = 11'd366;
    localparam logic [10:0] QD_YEAR2     = 11'd731;
    localparam logic [10:0] QD_YEAR3     = 11'd1096;
    localparam logic [11:0] YEAR_BASE    = 12'd1968;

    // Queue between front and back; depth must be a power of two
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

    // Register stages in the back part
    localparam int unsigned BACK_STAGES  = 5;

    // Front result: whole days and seconds of the day
    typedef struct packed {
        logic [15:0] days;
        logic [16:0] sod;
    } t_split;

    // Converted date and time
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_result;

    // First day of a month as day of year, from 0
    function automatic logic [8:0] month_start(input logic [3:0] month, input logic leap);
        logic [8:0] base;
        base = 9'd0;
        unique case (month)
            4'd1:    base = 9'd0;
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (month > 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

>>> rtl/core/ustd_front.sv
// Front: accepts seconds counts and splits them into days and seconds of the day.
module ustd_front
    import ustd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output t_split      o_split
);

    logic        r_v0;
    logic        r_v1;
    logic [15:0] r_q;
    logic [24:0] r_x;
    logic [6:0]  r_lo;
    t_split      r_split;

    logic        w_rdy0;
    logic        w_rdy1;
    logic [50:0] w_day_prod;
    logic [25:0] w_q_mul;
    logic [25:0] w_rem;

    // Ready chain through both stages
    assign w_rdy1  = !r_v1 || i_ready;
    assign w_rdy0  = !r_v0 || w_rdy1;
    assign o_ready = w_rdy0;

    // Stage 0: estimate days by reciprocal multiply (exact for all inputs)
    assign w_day_prod = 51'(i_seconds[31:SEC_LO_BITS]) * 51'(DAY_RECIP);

    // Stage 1: remainder gives seconds of day in units of 128 s
    assign w_q_mul = 26'(r_q) * 26'(DAY_DIV_HI);
    assign w_rem   = 26'(r_x) - w_q_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (w_rdy0) r_v0 <= i_valid;
            if (w_rdy1) r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy0) begin
            r_q  <= w_day_prod[DAY_SHIFT +: 16];
            r_x  <= i_seconds[31:SEC_LO_BITS];
            r_lo <= i_seconds[SEC_LO_BITS-1:0];
        end
        if (w_rdy1) begin
            r_split.days <= r_q;
            r_split.sod  <= {w_rem[9:0], r_lo};
        end
    end

    assign o_valid = r_v1;
    assign o_split = r_split;

endmodule

>>> rtl/core/ustd_queue.sv
// Short request queue between the front and back parts.
module ustd_queue
    import ustd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_split i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_split o_data
);

    t_split                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]         r_wr_ptr;
    logic [QUEUE_AW-1:0]         r_rd_ptr;
    logic [QUEUE_CW-1:0]         r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            if (w_pop)  r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            if (w_push && !w_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

>>> rtl/core/ustd_back.sv
// Back: turns days and seconds of day into calendar date and clock time.
module ustd_back
    import ustd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_split  i_split,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic [BACK_STAGES-1:0] r_valid;
    logic [BACK_STAGES:0]   w_rdy;

    // Stage 0
    logic [15:0] r_b0_d;
    logic [4:0]  r_b0_hour;
    logic [16:0] r_b0_sod;
    // Stage 1
    logic [15:0] r_b1_d;
    logic [5:0]  r_b1_quad;
    logic [11:0] r_b1_rem;
    logic [4:0]  r_b1_hour;
    // Stage 2
    logic [10:0] r_b2_r4;
    logic [5:0]  r_b2_quad;
    logic [5:0]  r_b2_min;
    logic [11:0] r_b2_rem;
    logic [4:0]  r_b2_hour;
    // Stage 3
    logic [11:0] r_b3_year;
    logic [8:0]  r_b3_doy;
    logic        r_b3_leap;
    logic [4:0]  r_b3_hour;
    logic [5:0]  r_b3_min;
    logic [5:0]  r_b3_sec;
    // Stage 4
    t_result     r_b4;

    logic [15:0] w_d;
    logic [32:0] w_hour_prod;
    logic [31:0] w_quad_prod;
    logic [16:0] w_hour_secs;
    logic [16:0] w_rem_full;
    logic [15:0] w_quad_days;
    logic [15:0] w_r4_full;
    logic [23:0] w_min_prod;
    logic [11:0] w_min_secs;
    logic [11:0] w_sec_full;
    logic [1:0]  w_yo;
    logic [10:0] w_yo_off;
    logic [10:0] w_doy_full;
    logic [3:0]  w_month;
    logic [8:0]  w_day_full;

    // Ready chain from the output register back to the queue
    always_comb begin
        w_rdy[BACK_STAGES] = i_ready;
        for (int i = BACK_STAGES - 1; i >= 0; i--) begin
            w_rdy[i] = !r_valid[i] || w_rdy[i+1];
        end
    end
    assign o_ready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_rdy[0]) r_valid[0] <= i_valid;
            for (int i = 1; i < BACK_STAGES; i++) begin
                if (w_rdy[i]) r_valid[i] <= r_valid[i-1];
            end
        end
    end

    // Stage 0: day number from 1968, with a phantom Feb 29 inserted for 2100
    assign w_d = i_split.days + EPOCH_OFFSET + 16'(i_split.days >= SKIP_2100);
    assign w_hour_prod = 33'(i_split.sod) * 33'(HOUR_RECIP);

    // Stage 1: four-year block and seconds within the hour
    assign w_quad_prod = 32'(r_b0_d) * 32'(QUAD_RECIP);
    assign w_hour_secs = 17'(r_b0_hour) * 17'(SECS_PER_HR);
    assign w_rem_full  = r_b0_sod - w_hour_secs;

    // Stage 2: day within block and minute
    assign w_quad_days = 16'(r_b1_quad) * 16'(DAYS_PER_QD);
    assign w_r4_full   = r_b1_d - w_quad_days;
    assign w_min_prod  = 24'(r_b1_rem) * 24'(MIN_RECIP);

    // Stage 3: year within block, day of year, second
    always_comb begin
        priority if (r_b2_r4 >= QD_YEAR3) begin
            w_yo = 2'd3;
            w_yo_off = QD_YEAR3;
        end else if (r_b2_r4 >= QD_YEAR2) begin
            w_yo = 2'd2;
            w_yo_off = QD_YEAR2;
        end else if (r_b2_r4 >= QD_YEAR1) begin
            w_yo = 2'd1;
            w_yo_off = QD_YEAR1;
        end else begin
            w_yo = 2'd0;
            w_yo_off = 11'd0;
        end
    end
    assign w_doy_full = r_b2_r4 - w_yo_off;
    assign w_min_secs = 12'(r_b2_min) * 12'(SECS_PER_MN);
    assign w_sec_full = r_b2_rem - w_min_secs;

    // Stage 4: month by comparing against month starts, then day of month
    always_comb begin
        w_month = 4'd1;
        for (int k = 2; k <= 12; k++) begin
            if (r_b3_doy >= month_start(4'(k), r_b3_leap)) w_month = 4'(k);
        end
    end
    assign w_day_full = r_b3_doy - month_start(w_month, r_b3_leap) + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_b0_d    <= w_d;
            r_b0_hour <= w_hour_prod[HOUR_SHIFT +: 5];
            r_b0_sod  <= i_split.sod;
        end
        if (w_rdy[1]) begin
            r_b1_d    <= r_b0_d;
            r_b1_quad <= w_quad_prod[QUAD_SHIFT +: 6];
            r_b1_rem  <= w_rem_full[11:0];
            r_b1_hour <= r_b0_hour;
        end
        if (w_rdy[2]) begin
            r_b2_r4   <= w_r4_full[10:0];
            r_b2_quad <= r_b1_quad;
            r_b2_min  <= w_min_prod[MIN_SHIFT +: 6];
            r_b2_rem  <= r_b1_rem;
            r_b2_hour <= r_b1_hour;
        end
        if (w_rdy[3]) begin
            r_b3_year <= YEAR_BASE + 12'({r_b2_quad, 2'b00}) + 12'(w_yo);
            r_b3_doy  <= w_doy_full[8:0];
            r_b3_leap <= (w_yo == 2'd0);
            r_b3_hour <= r_b2_hour;
            r_b3_min  <= r_b2_min;
            r_b3_sec  <= w_sec_full[5:0];
        end
        if (w_rdy[4]) begin
            r_b4.year   <= r_b3_year;
            r_b4.month  <= w_month;
            r_b4.day    <= w_day_full[4:0];
            r_b4.hour   <= r_b3_hour;
            r_b4.minute <= r_b3_min;
            r_b4.second <= r_b3_sec;
        end
    end

    assign o_valid  = r_valid[BACK_STAGES-1];
    assign o_result = r_b4;

endmodule

>>> rtl/core/unix_seconds_to_datetime.sv
// Top level: 32-bit Unix seconds to Gregorian date and 24-hour time.
// Request acceptance to o_m_axis_tvalid passes front 2, queue 1 and back 5 register stages;
// the accepting edge loads the first front stage.
// Throughput: one request per cycle while nothing stalls; the stages and the 4-entry queue then advance together.
// Backpressure stalls the back pipeline; the queue lets the front keep accepting until the queue is full.
// Reset (i_rst_n low, synchronous) clears all valid flags and queue pointers; no clear sweep.
module unix_seconds_to_datetime
    import ustd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] epoch_seconds
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata    // [11:0] cal_year, [15:12] cal_month,
                                          // [20:16] cal_day, [25:21] clock_hour,
                                          // [31:26] clock_minute, [37:32] clock_second,
                                          // [39:38] zero
);

    logic    w_f_valid;
    logic    w_f_ready;
    t_split  w_f_split;
    logic    w_q_valid;
    logic    w_q_ready;
    t_split  w_q_split;
    t_result w_result;

    ustd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_seconds (i_s_axis_tdata),
        .o_valid   (w_f_valid),
        .i_ready   (w_f_ready),
        .o_split   (w_f_split)
    );

    ustd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_split),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_split)
    );

    ustd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_split  (w_q_split),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    // Pack result fields, lowest field first
    assign o_m_axis_tdata = {2'b00, w_result.second, w_result.minute, w_result.hour,
                             w_result.day, w_result.month, w_result.year};

    // Output fields stay within calendar ranges
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_result.month >= 4'd1) && (w_result.month <= 4'd12) &&
                            (w_result.day >= 5'd1) && (w_result.hour <= 5'd23) &&
                            (w_result.minute <= 6'd59) && (w_result.second <= 6'd59))
        else $error("date/time field out of range");

    // Year limited to the span reachable by a 32-bit count
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_result.year >= 12'd1970) && (w_result.year <= 12'd2106))
        else $error("year out of range");

    // 2100 is not a leap year
    a_no_leap_2100: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_result.year == 12'd2100) && (w_result.month == 4'd2))
            |-> (w_result.day <= 5'd28))
        else $error("Feb 29 produced for 2100");

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule
